### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers used by billboard_facing_matrix.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define BFM_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define BFM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BFM_ASSERT(lbl, clk, rstn, prop, msg)
`define BFM_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

### rtl/bfm_pkg.sv
// ----------------------------------------------------------------------------
// bfm_pkg
// Constants, types and arithmetic helpers of the billboard facing matrix.
// ----------------------------------------------------------------------------
package bfm_pkg;

  localparam int COORD_WIDTH     = 32;
  localparam int COORD_FRAC_BITS = 16;

  localparam int LOOK_W     = COORD_WIDTH + 1;
  localparam int MSB_W      = $clog2(LOOK_W);
  localparam int NORM_W     = 31;
  localparam int ROOT_W     = NORM_W + 1;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int SREM_W     = ROOT_W + 3;
  localparam int Q_W        = COORD_FRAC_BITS + 1;
  localparam int DIV_STEPS  = Q_W;
  localparam int NUM_W      = NORM_W + Q_W;
  localparam int DREM_W     = ROOT_W + 1;
  localparam int SC_W       = 16;
  localparam int SC_FRAC    = 8;
  localparam int OUT_W      = 32;
  localparam int PW         = 2 * COORD_FRAC_BITS + SC_W + 4;
  localparam int N_STAGES   = 6 + SQRT_STEPS + DIV_STEPS + 5;

  localparam logic [Q_W-1:0] ONE = Q_W'(1) << COORD_FRAC_BITS;
  localparam logic signed [PW-1:0] OUT_MAX = PW'((64'sd1 <<< (OUT_W - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] OUT_MIN = -OUT_MAX - PW'(64'sd1);

  typedef enum logic [1:0] {
    REG_VIEWER_X = 2'd0,
    REG_VIEWER_Y = 2'd1,
    REG_VIEWER_Z = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SREM_W-1:0] rem;
    logic [ROOT_W-1:0] root;
    logic [RAD_W-1:0]  rad;
  } sqrt_stage_t;

  typedef struct packed {
    logic [DREM_W-1:0] rem;
    logic [Q_W-1:0]    quo;
    logic [Q_W-1:0]    low;
    logic [ROOT_W-1:0] den;
  } div_stage_t;

  typedef struct packed {
    logic [NORM_W-1:0] a_y;
    logic [NORM_W-1:0] b_y;
    logic [NORM_W-1:0] a_x;
    logic [NORM_W-1:0] b_x;
  } ab_t;

  typedef struct packed {
    logic [SC_W-1:0] sx;
    logic [SC_W-1:0] sy;
    logic            pos_y;
    logic            pos_x;
    logic            deg_y;
    logic            deg_x;
  } meta_t;

  function automatic logic [LOOK_W-1:0] abs_mag(input logic signed [LOOK_W-1:0] v);
    return v[LOOK_W-1] ? LOOK_W'(-v) : LOOK_W'(v);
  endfunction

  function automatic logic [MSB_W-1:0] msb_idx(input logic [LOOK_W-1:0] v);
    logic [MSB_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < LOOK_W; i++) begin
      if (v[i]) idx = MSB_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [NORM_W-1:0] norm_mag(input logic [LOOK_W-1:0] v,
                                                 input logic [MSB_W-1:0] msb);
    logic [LOOK_W+NORM_W-1:0] t;
    t = {{NORM_W{1'b0}}, v};
    if (msb > MSB_W'(NORM_W - 1)) t = t >> (msb - MSB_W'(NORM_W - 1));
    else t = t << (MSB_W'(NORM_W - 1) - msb);
    return t[NORM_W-1:0];
  endfunction

  function automatic sqrt_stage_t sqrt_step(input sqrt_stage_t s);
    sqrt_stage_t o;
    logic [SREM_W-1:0] r;
    logic [SREM_W-1:0] trial;
    r     = {s.rem[SREM_W-3:0], s.rad[RAD_W-1 -: 2]};
    trial = {{(SREM_W-ROOT_W-2){1'b0}}, s.root, 2'b01};
    o.rad = s.rad << 2;
    if (r >= trial) begin
      o.rem  = r - trial;
      o.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem  = r;
      o.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_stage_t div_step(input div_stage_t s);
    div_stage_t o;
    logic [DREM_W-1:0] r;
    r     = {s.rem[DREM_W-2:0], s.low[Q_W-1]};
    o.low = s.low << 1;
    o.den = s.den;
    if (r >= {1'b0, s.den}) begin
      o.rem = r - {1'b0, s.den};
      o.quo = {s.quo[Q_W-2:0], 1'b1};
    end else begin
      o.rem = r;
      o.quo = {s.quo[Q_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [PW-1:0] rnd_sc(input logic signed [PW-1:0] v);
    return (v + $signed(PW'(1) << (SC_FRAC - 1))) >>> SC_FRAC;
  endfunction

  function automatic logic signed [PW-1:0] rnd_frac(input logic signed [PW-1:0] v);
    return (v + $signed(PW'(1) << (COORD_FRAC_BITS - 1))) >>> COORD_FRAC_BITS;
  endfunction

  function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [PW-1:0] v);
    if (v > OUT_MAX) return OUT_W'(OUT_MAX);
    if (v < OUT_MIN) return OUT_W'(OUT_MIN);
    return v[OUT_W-1:0];
  endfunction

endpackage

### rtl/bfm_sqrt.sv
// ----------------------------------------------------------------------------
// bfm_sqrt
// Pipelined floor square root, one result bit per stage.
// ----------------------------------------------------------------------------
module bfm_sqrt import bfm_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [RAD_W-1:0]  rad_i,
  output logic [ROOT_W-1:0] root_o
);

  sqrt_stage_t st_q [SQRT_STEPS];
  sqrt_stage_t seed;

  always_comb begin
    seed.rem  = '0;
    seed.root = '0;
    seed.rad  = rad_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= sqrt_step(seed);
      for (int i = 1; i < SQRT_STEPS; i++) begin
        st_q[i] <= sqrt_step(st_q[i-1]);
      end
    end
  end

  assign root_o = st_q[SQRT_STEPS-1].root;

endmodule

### rtl/bfm_div.sv
// ----------------------------------------------------------------------------
// bfm_div
// Pipelined restoring divider for the rounded ratio (num*2^F + den/2)/den.
// ----------------------------------------------------------------------------
module bfm_div import bfm_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [NORM_W-1:0] num_i,
  input  logic [ROOT_W-1:0] den_i,
  output logic [Q_W-1:0]    quo_o
);

  div_stage_t st_q [DIV_STEPS];
  div_stage_t seed;
  logic [NUM_W-1:0] dividend;

  always_comb begin
    dividend  = {num_i, {COORD_FRAC_BITS{1'b0}}} + NUM_W'(den_i >> 1);
    seed.rem  = {{(DREM_W-NORM_W){1'b0}}, dividend[NUM_W-1:Q_W]};
    seed.quo  = '0;
    seed.low  = dividend[Q_W-1:0];
    seed.den  = den_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      st_q[0] <= div_step(seed);
      for (int i = 1; i < DIV_STEPS; i++) begin
        st_q[i] <= div_step(st_q[i-1]);
      end
    end
  end

  assign quo_o = st_q[DIV_STEPS-1].quo;

endmodule

### rtl/billboard_facing_matrix.sv
// ----------------------------------------------------------------------------
// billboard_facing_matrix
// Rotation-and-scale matrix that turns a billboard toward the viewer.
// ----------------------------------------------------------------------------
// Usage:
//   Config: write viewer_x/y/z (index 0..2) through cfg_we_i/cfg_idx_i/
//   cfg_data_i while the block is idle; other indexes are ignored.
//   Input channel: one beat per billboard (position, Q8.8 scale), taken
//   when in_valid_i and in_ready_o are both high.
//   Output channel: one beat per input with the nine matrix entries and
//   the degenerate flag, taken when out_valid_o and out_ready_i are high.
//   Pipeline: 6 front stages, 32 square-root stages, 17 divider stages
//   and 5 product stages from input beat to output beat.
//   Throughput: one beat per cycle unless stalled; all stages step together.
//   Stall: when the output holds a beat that is not taken, the whole
//   pipeline freezes and in_ready_o drops; nothing is lost or repeated.
//   Reset: viewer registers clear to zero and all stage valids clear.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module billboard_facing_matrix import bfm_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [1:0]                    cfg_idx_i,
  input  logic [COORD_WIDTH-1:0]        cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [COORD_WIDTH-1:0] pos_x_i,
  input  logic signed [COORD_WIDTH-1:0] pos_y_i,
  input  logic signed [COORD_WIDTH-1:0] pos_z_i,
  input  logic [SC_W-1:0]               scale_x_i,
  input  logic [SC_W-1:0]               scale_y_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [OUT_W-1:0]       m00_o,
  output logic signed [OUT_W-1:0]       m01_o,
  output logic signed [OUT_W-1:0]       m02_o,
  output logic signed [OUT_W-1:0]       m10_o,
  output logic signed [OUT_W-1:0]       m11_o,
  output logic signed [OUT_W-1:0]       m12_o,
  output logic signed [OUT_W-1:0]       m20_o,
  output logic signed [OUT_W-1:0]       m21_o,
  output logic signed [OUT_W-1:0]       m22_o,
  output logic                          degenerate_o
);

  localparam logic signed [OUT_W-1:0] ONE_S = OUT_W'(ONE);

  logic signed [COORD_WIDTH-1:0] viewer_x_q, viewer_y_q, viewer_z_q;
  logic [N_STAGES-1:0] vld_q;
  logic pipe_en;

  assign pipe_en    = !vld_q[N_STAGES-1] || out_ready_i;
  assign in_ready_o = pipe_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      viewer_x_q <= '0;
      viewer_y_q <= '0;
      viewer_z_q <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_VIEWER_X: viewer_x_q <= cfg_data_i;
        REG_VIEWER_Y: viewer_y_q <= cfg_data_i;
        REG_VIEWER_Z: viewer_z_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (pipe_en) begin
      vld_q <= {vld_q[N_STAGES-2:0], in_valid_i};
    end
  end

  // stage 1: look vector
  logic signed [LOOK_W-1:0] lx_q, ly_q, lz_q;
  logic [SC_W-1:0] sx1_q, sy1_q;
  // stage 2: magnitudes, signs, degenerate flags
  logic [LOOK_W-1:0] mx_q, my_q, mz_q, maxy_q, maxx_q;
  meta_t meta2_q, meta3_q, meta4_q, meta5_q, meta6_q;
  // stage 3: normalize shift
  logic [LOOK_W-1:0] mx3_q, my3_q, mz3_q;
  logic [MSB_W-1:0] msby_q, msbx_q;
  // stage 4..6
  ab_t ab4_q, ab5_q, ab6_q;
  logic [2*NORM_W-1:0] sqay_q, sqby_q, sqax_q, sqbx_q;
  logic [RAD_W-1:0] rady_q, radx_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      lx_q  <= LOOK_W'(viewer_x_q) - LOOK_W'(pos_x_i);
      ly_q  <= LOOK_W'(viewer_y_q) - LOOK_W'(pos_y_i);
      lz_q  <= LOOK_W'(viewer_z_q) - LOOK_W'(pos_z_i);
      sx1_q <= scale_x_i;
      sy1_q <= scale_y_i;

      mx_q   <= abs_mag(lx_q);
      my_q   <= abs_mag(ly_q);
      mz_q   <= abs_mag(lz_q);
      maxy_q <= (abs_mag(lz_q) > abs_mag(lx_q)) ? abs_mag(lz_q) : abs_mag(lx_q);
      maxx_q <= (abs_mag(lz_q) > abs_mag(ly_q)) ? abs_mag(lz_q) : abs_mag(ly_q);
      meta2_q.sx    <= sx1_q;
      meta2_q.sy    <= sy1_q;
      meta2_q.pos_y <= (lx_q != '0) && (lz_q != '0) && (lx_q[LOOK_W-1] == lz_q[LOOK_W-1]);
      meta2_q.pos_x <= (ly_q != '0) && (lz_q != '0) && (ly_q[LOOK_W-1] != lz_q[LOOK_W-1]);
      meta2_q.deg_y <= (lx_q == '0) && (lz_q == '0);
      meta2_q.deg_x <= (ly_q == '0) && (lz_q == '0);

      mx3_q   <= mx_q;
      my3_q   <= my_q;
      mz3_q   <= mz_q;
      msby_q  <= msb_idx(maxy_q);
      msbx_q  <= msb_idx(maxx_q);
      meta3_q <= meta2_q;

      ab4_q.a_y <= norm_mag(mz3_q, msby_q);
      ab4_q.b_y <= norm_mag(mx3_q, msby_q);
      ab4_q.a_x <= norm_mag(mz3_q, msbx_q);
      ab4_q.b_x <= norm_mag(my3_q, msbx_q);
      meta4_q   <= meta3_q;

      sqay_q  <= ab4_q.a_y * ab4_q.a_y;
      sqby_q  <= ab4_q.b_y * ab4_q.b_y;
      sqax_q  <= ab4_q.a_x * ab4_q.a_x;
      sqbx_q  <= ab4_q.b_x * ab4_q.b_x;
      ab5_q   <= ab4_q;
      meta5_q <= meta4_q;

      rady_q  <= RAD_W'(sqay_q) + RAD_W'(sqby_q);
      radx_q  <= RAD_W'(sqax_q) + RAD_W'(sqbx_q);
      ab6_q   <= ab5_q;
      meta6_q <= meta5_q;
    end
  end

  // square roots, with operands and side data delayed alongside
  logic [ROOT_W-1:0] root_y, root_x;
  ab_t   ab_dly_q   [SQRT_STEPS];
  meta_t meta_dly_q [SQRT_STEPS+DIV_STEPS];

  bfm_sqrt u_sqrt_y (.clk_i, .en_i(pipe_en), .rad_i(rady_q), .root_o(root_y));
  bfm_sqrt u_sqrt_x (.clk_i, .en_i(pipe_en), .rad_i(radx_q), .root_o(root_x));

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      ab_dly_q[0]   <= ab6_q;
      meta_dly_q[0] <= meta6_q;
      for (int i = 1; i < SQRT_STEPS; i++) ab_dly_q[i] <= ab_dly_q[i-1];
      for (int i = 1; i < SQRT_STEPS + DIV_STEPS; i++) meta_dly_q[i] <= meta_dly_q[i-1];
    end
  end

  logic [Q_W-1:0] qay, qby, qax, qbx;
  ab_t ab_r;
  assign ab_r = ab_dly_q[SQRT_STEPS-1];

  bfm_div u_div_ay (.clk_i, .en_i(pipe_en), .num_i(ab_r.a_y), .den_i(root_y), .quo_o(qay));
  bfm_div u_div_by (.clk_i, .en_i(pipe_en), .num_i(ab_r.b_y), .den_i(root_y), .quo_o(qby));
  bfm_div u_div_ax (.clk_i, .en_i(pipe_en), .num_i(ab_r.a_x), .den_i(root_x), .quo_o(qax));
  bfm_div u_div_bx (.clk_i, .en_i(pipe_en), .num_i(ab_r.b_x), .den_i(root_x), .quo_o(qbx));

  meta_t md;
  logic [Q_W-1:0] cqay, cqby, cqax, cqbx, smy, smx;
  assign md   = meta_dly_q[SQRT_STEPS+DIV_STEPS-1];
  assign cqay = (qay > ONE) ? ONE : qay;
  assign cqby = (qby > ONE) ? ONE : qby;
  assign cqax = (qax > ONE) ? ONE : qax;
  assign cqbx = (qbx > ONE) ? ONE : qbx;
  assign smy  = md.deg_y ? '0 : cqby;
  assign smx  = md.deg_x ? '0 : cqbx;

  // product stages
  logic [Q_W-1:0] cy_q, cx_q;
  logic signed [Q_W:0] syn_q, sxn_q, syn3_q, syn4_q, t1_q, t2_q;
  logic [SC_W-1:0] sx_f1_q, sy_f1_q, sx_f2_q, sx_f3_q;
  logic deg_f1_q, deg_f2_q, deg_f3_q, deg_f4_q;
  logic signed [Q_W:0] syn2_q;
  logic signed [PW-1:0] p00_q, pyx_q, pnyc_q, p11_q, p12_q, p21_q, p22_q;
  logic signed [PW-1:0] r00_q, r11_q, r12_q, r21_q, r22_q;
  logic signed [PW-1:0] r00b_q, r11b_q, r12b_q, r21b_q, r22b_q, p01_q, p02_q;
  logic signed [OUT_W-1:0] m00_q, m01_q, m02_q, m11_q, m12_q, m20_q, m21_q, m22_q;
  logic deg_q;

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      cy_q     <= md.deg_y ? ONE : cqay;
      cx_q     <= md.deg_x ? ONE : cqax;
      syn_q    <= md.pos_y ? $signed({1'b0, smy}) : -$signed({1'b0, smy});
      sxn_q    <= md.pos_x ? $signed({1'b0, smx}) : -$signed({1'b0, smx});
      sx_f1_q  <= md.sx;
      sy_f1_q  <= md.sy;
      deg_f1_q <= md.deg_y || md.deg_x;

      p00_q    <= $signed({1'b0, sx_f1_q}) * $signed({1'b0, cy_q});
      pyx_q    <= syn_q * sxn_q;
      pnyc_q   <= -($signed({1'b0, cx_q}) * syn_q);
      p11_q    <= $signed({1'b0, sy_f1_q}) * $signed({1'b0, cx_q});
      p12_q    <= $signed({1'b0, sy_f1_q}) * sxn_q;
      p21_q    <= -($signed({1'b0, cy_q}) * sxn_q);
      p22_q    <= $signed({1'b0, cy_q}) * $signed({1'b0, cx_q});
      syn2_q   <= syn_q;
      sx_f2_q  <= sx_f1_q;
      deg_f2_q <= deg_f1_q;

      r00_q    <= rnd_sc(p00_q);
      t1_q     <= (Q_W+1)'(rnd_frac(pyx_q));
      t2_q     <= (Q_W+1)'(rnd_frac(pnyc_q));
      r11_q    <= rnd_sc(p11_q);
      r12_q    <= rnd_sc(p12_q);
      r21_q    <= rnd_frac(p21_q);
      r22_q    <= rnd_frac(p22_q);
      syn3_q   <= syn2_q;
      sx_f3_q  <= sx_f2_q;
      deg_f3_q <= deg_f2_q;

      p01_q    <= $signed({1'b0, sx_f3_q}) * t1_q;
      p02_q    <= $signed({1'b0, sx_f3_q}) * t2_q;
      r00b_q   <= r00_q;
      r11b_q   <= r11_q;
      r12b_q   <= r12_q;
      r21b_q   <= r21_q;
      r22b_q   <= r22_q;
      syn4_q   <= syn3_q;
      deg_f4_q <= deg_f3_q;

      m00_q <= sat_out(r00b_q);
      m01_q <= sat_out(rnd_sc(p01_q));
      m02_q <= sat_out(rnd_sc(p02_q));
      m11_q <= sat_out(r11b_q);
      m12_q <= sat_out(r12b_q);
      m20_q <= sat_out(PW'(syn4_q));
      m21_q <= sat_out(r21b_q);
      m22_q <= sat_out(r22b_q);
      deg_q <= deg_f4_q;
    end
  end

  assign out_valid_o  = vld_q[N_STAGES-1];
  assign m00_o        = m00_q;
  assign m01_o        = m01_q;
  assign m02_o        = m02_q;
  assign m10_o        = '0;
  assign m11_o        = m11_q;
  assign m12_o        = m12_q;
  assign m20_o        = m20_q;
  assign m21_o        = m21_q;
  assign m22_o        = m22_q;
  assign degenerate_o = deg_q;

  `BFM_ASSERT(a_stall_freezes, clk_i, rst_ni, !pipe_en |=> $stable(vld_q), "pipeline moved during stall")
  `BFM_ASSERT(a_m22_nonneg, clk_i, rst_ni, out_valid_o |-> !m22_o[OUT_W-1], "m22 negative")
  `BFM_ASSERT(a_m20_range, clk_i, rst_ni, out_valid_o |-> (m20_o <= ONE_S && m20_o >= -ONE_S), "m20 beyond unit")

endmodule
